@@ rtl/gnpim_pkg.sv @@
// gnpim_pkg: shared constants for the grid nearest-point index map
// register index codes, field widths and parameter defaults
// no dependencies
package gnpim_pkg;

   localparam int DIM_BITS_DEF  = 16;
   localparam int FRAC_BITS_DEF = 16;

   localparam int IDX_W     = 16;
   localparam int SCALE_W   = 32;
   localparam int BASE_W    = 32;
   localparam int DIMS_W    = 48;
   localparam int LIN_W     = 48;
   localparam int FIELD_W   = 16;
   localparam int NUM_AXES  = 3;
   localparam int CSR_IDX_W = 4;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0001_0000;

   localparam logic [CSR_IDX_W-1:0] REG_SCALE_X     = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_Y     = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_Z     = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_X      = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_Y      = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_Z      = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_DIMS = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_REF_DIMS    = 4'd7;

endpackage

@@ rtl/grid_nearest_point_index_map_top.sv @@
// grid_nearest_point_index_map_top: maps a reference voxel to the nearest sample voxel
// four-stage pipeline plus config registers; depends on gnpim_pkg
// throughput: one word per cycle unless rsp_stall holds the output register;
// each stage takes a new word when it empties or moves on, so bubbles close up
// while the output register is stalled
// limits: one layer of 16x32 multipliers per stage
// reset: clears all stage valid bits and loads scale 1.0, base 0, dims 0
module grid_nearest_point_index_map_top #(
   parameter int DIM_BITS  = gnpim_pkg::DIM_BITS_DEF,
   parameter int FRAC_BITS = gnpim_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [gnpim_pkg::IDX_W-1:0]     req_ref_col,
   input  logic [gnpim_pkg::IDX_W-1:0]     req_ref_row,
   input  logic [gnpim_pkg::IDX_W-1:0]     req_ref_plane,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_hit,
   output logic [gnpim_pkg::LIN_W-1:0]     rsp_sample_index,
   output logic [gnpim_pkg::LIN_W-1:0]     rsp_ref_index,
   // config write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [gnpim_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gnpim_pkg::DIMS_W-1:0]    csr_wdata
);
   import gnpim_pkg::*;

   localparam int KW  = DIM_BITS;
   localparam int PRW = KW + SCALE_W;     // idx * scale
   localparam int PW  = KW + SCALE_W + 2; // signed position
   localparam int FLW = PW - 1 - FRAC_BITS;
   localparam int SW  = 3 * KW;
   localparam int RW  = 3 * KW + 1;

   // ---------------- config registers ----------------
   logic [SCALE_W-1:0] scale_ff [NUM_AXES];
   logic [BASE_W-1:0]  base_ff  [NUM_AXES];
   logic [DIMS_W-1:0]  sample_dims_ff;
   logic [DIMS_W-1:0]  ref_dims_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            scale_ff[a] <= SCALE_RESET;
            base_ff[a]  <= '0;
         end
         sample_dims_ff <= '0;
         ref_dims_ff    <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_SCALE_X:     scale_ff[0]    <= csr_wdata[SCALE_W-1:0];
            REG_SCALE_Y:     scale_ff[1]    <= csr_wdata[SCALE_W-1:0];
            REG_SCALE_Z:     scale_ff[2]    <= csr_wdata[SCALE_W-1:0];
            REG_BASE_X:      base_ff[0]     <= csr_wdata[BASE_W-1:0];
            REG_BASE_Y:      base_ff[1]     <= csr_wdata[BASE_W-1:0];
            REG_BASE_Z:      base_ff[2]     <= csr_wdata[BASE_W-1:0];
            REG_SAMPLE_DIMS: sample_dims_ff <= csr_wdata;
            REG_REF_DIMS:    ref_dims_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   logic [KW-1:0] sext [NUM_AXES];
   logic [KW-1:0] rext [2];

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         sext[a] = sample_dims_ff[FIELD_W*a +: KW];
      end
      for (int a = 0; a < 2; a++) begin
         rext[a] = ref_dims_ff[FIELD_W*a +: KW];
      end
   end

   // ---------------- stage enables ----------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic en1, en2, en3, out_en;

   assign out_en    = !rsp_valid_ff || !rsp_stall;
   assign en3       = !s3_valid_ff || out_en;
   assign en2       = !s2_valid_ff || en3;
   assign en1       = !s1_valid_ff || en2;
   assign req_stall = !en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1)    s1_valid_ff  <= req_valid;
         if (en2)    s2_valid_ff  <= s1_valid_ff;
         if (en3)    s3_valid_ff  <= s2_valid_ff;
         if (out_en) rsp_valid_ff <= s3_valid_ff;
      end
   end

   // ---------------- stage 1: idx * scale, extent products ----------------
   logic [KW-1:0]   k_in [NUM_AXES];
   logic [PRW-1:0]  s1_prod_in [NUM_AXES];
   logic [PRW-1:0]  s1_prod_ff [NUM_AXES];
   logic [KW-1:0]   s1_k_ff [NUM_AXES];
   logic [2*KW-1:0] s1_sxsy_in, s1_sxsy_ff;
   logic [2*KW-1:0] s1_rxry_in, s1_rxry_ff;

   always_comb begin
      k_in[0] = req_ref_col[KW-1:0];
      k_in[1] = req_ref_row[KW-1:0];
      k_in[2] = req_ref_plane[KW-1:0];
      for (int a = 0; a < NUM_AXES; a++) begin
         s1_prod_in[a] = {{SCALE_W{1'b0}}, k_in[a]} * {{KW{1'b0}}, scale_ff[a]};
      end
      s1_sxsy_in = {{KW{1'b0}}, sext[0]} * {{KW{1'b0}}, sext[1]};
      s1_rxry_in = {{KW{1'b0}}, rext[0]} * {{KW{1'b0}}, rext[1]};
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_prod_ff <= s1_prod_in;
         s1_k_ff    <= k_in;
         s1_sxsy_ff <= s1_sxsy_in;
         s1_rxry_ff <= s1_rxry_in;
      end
   end

   // ---------------- stage 2: add base, floor, range check ----------------
   logic [PW-1:0]   pos_in [NUM_AXES];
   logic [FLW-1:0]  fl_in [NUM_AXES];
   logic [NUM_AXES-1:0] axis_hit;
   logic [KW-1:0]   s2_cell_in [NUM_AXES];
   logic [KW-1:0]   s2_cell_ff [NUM_AXES];
   logic            s2_hit_ff;
   logic [2*KW-1:0] s2_sxsy_ff;
   logic [SW-1:0]   s2_rz_in, s2_rz_ff;
   logic [2*KW-1:0] s2_ry_in, s2_ry_ff;
   logic [KW-1:0]   s2_kx_ff;

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         pos_in[a] = {2'b00, s1_prod_ff[a]}
                   + {{(PW-BASE_W){base_ff[a][BASE_W-1]}}, base_ff[a]};
         fl_in[a]  = pos_in[a][FRAC_BITS +: FLW];
         // negative position or floor past the extent is a miss
         axis_hit[a] = !pos_in[a][PW-1]
                     && (fl_in[a] < {{(FLW-KW){1'b0}}, sext[a]});
         s2_cell_in[a] = fl_in[a][KW-1:0];
      end
      s2_rz_in = {{(2*KW){1'b0}}, s1_k_ff[2]} * {{KW{1'b0}}, s1_rxry_ff};
      s2_ry_in = {{KW{1'b0}}, s1_k_ff[1]} * {{KW{1'b0}}, rext[0]};
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_hit_ff  <= &axis_hit;
         s2_cell_ff <= s2_cell_in;
         s2_sxsy_ff <= s1_sxsy_ff;
         s2_rz_ff   <= s2_rz_in;
         s2_ry_ff   <= s2_ry_in;
         s2_kx_ff   <= s1_k_ff[0];
      end
   end

   // ---------------- stage 3: sample partial products, ref sum ----------------
   logic [SW-1:0]   s3_pz_in, s3_pz_ff;
   logic [2*KW-1:0] s3_py_in, s3_py_ff;
   logic [KW-1:0]   s3_col_ff;
   logic            s3_hit_ff;
   logic [RW-1:0]   s3_ref_in, s3_ref_ff;

   always_comb begin
      s3_pz_in  = {{(2*KW){1'b0}}, s2_cell_ff[2]} * {{KW{1'b0}}, s2_sxsy_ff};
      s3_py_in  = {{KW{1'b0}}, s2_cell_ff[1]} * {{KW{1'b0}}, sext[0]};
      s3_ref_in = {1'b0, s2_rz_ff} + {{(KW+1){1'b0}}, s2_ry_ff}
                + {{(2*KW+1){1'b0}}, s2_kx_ff};
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_pz_ff  <= s3_pz_in;
         s3_py_ff  <= s3_py_in;
         s3_col_ff <= s2_cell_ff[0];
         s3_hit_ff <= s2_hit_ff;
         s3_ref_ff <= s3_ref_in;
      end
   end

   // ---------------- stage 4: output register ----------------
   logic [SW-1:0]    samp_sum;
   logic             rsp_hit_ff;
   logic [LIN_W-1:0] rsp_sample_index_ff;
   logic [LIN_W-1:0] rsp_ref_index_ff;

   // a hit keeps every cell inside the grid, so the sum fits in 3*DIM_BITS
   assign samp_sum = s3_pz_ff + {{KW{1'b0}}, s3_py_ff} + {{(2*KW){1'b0}}, s3_col_ff};

   always_ff @(posedge clock) begin
      if (out_en) begin
         rsp_hit_ff          <= s3_hit_ff;
         rsp_sample_index_ff <= s3_hit_ff ? LIN_W'(samp_sum) : '0;
         rsp_ref_index_ff    <= LIN_W'(s3_ref_ff);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_sample_index = rsp_sample_index_ff;
   assign rsp_ref_index    = rsp_ref_index_ff;

   // ---------------- assertions ----------------
   a_miss_zero_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_hit_ff) |-> (rsp_sample_index_ff == '0))
      else $error("miss word carries a nonzero sample index");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s2_valid_ff && s3_valid_ff && rsp_valid_ff
                     && rsp_stall))
      else $error("request stalled while the pipeline has a free slot");

   a_accept_enters_s1: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s1_valid_ff)
      else $error("accepted request word missing from stage 1");

   a_held_word_stays: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && !en3) |=> (s3_valid_ff && $stable(s3_ref_ff)))
      else $error("stage 3 word changed while blocked");

endmodule
